/* sv/chd_pkg.sv */
// Package: shared types, codes and constants of the chunked body decoder.
`timescale 1ns / 1ps

package chd_pkg;

  // Default width of the chunk length register
  localparam int unsigned LEN_BITS_DEF = 32;

  // Depth of the queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Framing characters
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // Status codes of a result
  localparam logic [1:0] STAT_BUSY  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_ERROR = 2'd2;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATA_CR = 3'd4,
    PH_DATA_LF = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  // Classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
    logic       is_hex;
    logic [3:0] nibble;
  } chd_item_t;

  // Result fields of one byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] status;
    logic       body_last;
  } chd_res_t;

endpackage

/* sv/chd_if.sv */
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps

interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_body;

  modport source (output valid, output in_byte, output end_of_body, input ready);
  modport sink (input valid, input in_byte, input end_of_body, output ready);
endinterface

interface chd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [1:0] status;
  logic       body_last;

  modport source (output valid, output out_byte, output out_valid, output status,
                  output body_last, input ready);
  modport sink (input valid, input out_byte, input out_valid, input status,
                input body_last, output ready);
endinterface

/* sv/chd_front.sv */
// Front: accept raw body bytes and classify them for the back.
`timescale 1ns / 1ps

module chd_front
  import chd_pkg::*;
(
  chd_in_if.sink    in_i,
  input  logic      q_ready_i,
  output logic      push_o,
  output chd_item_t item_o
);

  // Accept whenever the queue has room
  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;

  // Classify the byte: framing characters and hex digit value
  always_comb begin
    item_o         = '0;
    item_o.data    = in_i.in_byte;
    item_o.last    = in_i.end_of_body;
    item_o.is_cr   = (in_i.in_byte == CH_CR);
    item_o.is_lf   = (in_i.in_byte == CH_LF);
    item_o.is_semi = (in_i.in_byte == CH_SEMI);
    if (in_i.in_byte >= 8'h30 && in_i.in_byte <= 8'h39) begin
      item_o.is_hex = 1'b1;
      item_o.nibble = in_i.in_byte[3:0];
    end else if ((in_i.in_byte >= 8'h61 && in_i.in_byte <= 8'h66) ||
                 (in_i.in_byte >= 8'h41 && in_i.in_byte <= 8'h46)) begin
      // Letters a-f and A-F share the low three bits; value is 9 plus them
      item_o.is_hex = 1'b1;
      item_o.nibble = 4'd9 + {1'b0, in_i.in_byte[2:0]};
    end
  end

endmodule

/* sv/chd_queue.sv */
// Queue: short FIFO of classified bytes between front and back.
`timescale 1ns / 1ps

module chd_queue
  import chd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  chd_item_t item_i,
  output logic      ready_o,
  output logic      head_valid_o,
  output chd_item_t head_o,
  input  logic      pop_i
);

  chd_item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;

  assign ready_o      = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Never overfilled, never popped empty
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

endmodule

/* sv/chd_back.sv */
// Back: run the chunk framing state machine and hold the result register.
`timescale 1ns / 1ps

module chd_back
  import chd_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  chd_item_t head_i,
  output logic      pop_o,
  chd_out_if.source out_o
);

  phase_e              phase_q, phase_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic                seen_q, seen_d;
  logic                ovld_q;
  chd_res_t            res_q, res_d;
  logic                size_ok;

  // Take the next item when the result register is free or being drained
  assign pop_o = head_valid_i && (!ovld_q || out_o.ready);

  // A digit may enter only while the top nibble of the length is clear
  assign size_ok = head_i.is_hex && (len_q[LEN_BITS-1 -: 4] == 4'd0);

  // Next state
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    seen_d  = seen_q;
    case (phase_q)
      PH_SIZE: begin
        if (head_i.is_semi) begin
          phase_d = PH_EXT;
        end else if (head_i.is_cr) begin
          phase_d = seen_q ? PH_SIZE_LF : PH_ERROR;
        end else if (!size_ok) begin
          phase_d = PH_ERROR;
        end else begin
          len_d  = {len_q[LEN_BITS-5:0], head_i.nibble};
          seen_d = 1'b1;
        end
      end
      PH_EXT: begin
        if (head_i.is_cr) begin
          phase_d = seen_q ? PH_SIZE_LF : PH_ERROR;
        end else if (head_i.is_lf) begin
          phase_d = PH_ERROR;
        end
      end
      PH_SIZE_LF: begin
        if (!head_i.is_lf) begin
          phase_d = PH_ERROR;
        end else if (len_q == '0) begin
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        len_d = len_q - LEN_BITS'(1);
        if (len_q == LEN_BITS'(1)) begin
          phase_d = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        phase_d = head_i.is_cr ? PH_DATA_LF : PH_ERROR;
      end
      PH_DATA_LF: begin
        if (head_i.is_lf) begin
          phase_d = PH_SIZE;
          len_d   = '0;
          seen_d  = 1'b0;
        end else begin
          phase_d = PH_ERROR;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res_d           = '0;
    res_d.out_valid = (phase_q == PH_DATA);
    res_d.out_byte  = res_d.out_valid ? head_i.data : 8'd0;
    res_d.body_last = head_i.last;
    if (phase_d == PH_DONE) begin
      res_d.status = STAT_DONE;
    end else if (phase_d == PH_ERROR || head_i.last) begin
      res_d.status = STAT_ERROR;
    end else begin
      res_d.status = STAT_BUSY;
    end
  end

  // Update state on each transfer; drop back to the size line at body end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      len_q   <= '0;
      seen_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        if (head_i.last) begin
          phase_q <= PH_SIZE;
          len_q   <= '0;
          seen_q  <= 1'b0;
        end else begin
          phase_q <= phase_d;
          len_q   <= len_d;
          seen_q  <= seen_d;
        end
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = ovld_q;
  assign out_o.out_byte  = res_q.out_byte;
  assign out_o.out_valid = res_q.out_valid;
  assign out_o.status    = res_q.status;
  assign out_o.body_last = res_q.body_last;

  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> len_q != '0)
    else $error("data phase with zero length");
  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && res_q.body_last |-> res_q.status != STAT_BUSY)
    else $error("body end without final status");
  a_payload_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && res_q.out_valid && !res_q.body_last |-> res_q.status == STAT_BUSY)
    else $error("payload byte with final status");
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.last |=> phase_q == PH_SIZE && len_q == '0 && !seen_q)
    else $error("state not cleared after body end");

endmodule

/* sv/http_chunked_body_decoder.sv */
// Top level: HTTP chunked body decoder, front classifier, queue and back engine.
//
//   channel | dir | handshake      | payload
//   in_i    | in  | valid / ready  | in_byte[7:0], end_of_body
//   out_o   | out | valid / ready  | out_byte[7:0], out_valid, status[1:0], body_last
//
// One result per input byte. A byte passes through a queue entry and then
// the output register; one byte per cycle is sustained while the output is
// ready, since the back updates its phase and length with each byte taken.
// The two-entry queue lets the front keep accepting while the output stalls.
// Reset clears the queue, the phase, the length and the output valid.
`timescale 1ns / 1ps

module http_chunked_body_decoder
  import chd_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  chd_in_if.sink    in_i,
  chd_out_if.source out_o
);

  logic      push;
  logic      pop;
  logic      q_ready;
  logic      head_valid;
  chd_item_t item;
  chd_item_t head;

  chd_front u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .item_o    (item)
  );

  chd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .ready_o      (q_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  chd_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
